// ----- rtl/scc_pkg.sv -----
// Package: item types, configuration type, codes and constants of the stepper command controller
`default_nettype none
package scc_pkg;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_KEEPALIVE = 4'd1,
    OP_STATUS    = 4'd2,
    OP_SET       = 4'd3,
    OP_CLR_COUNT = 4'd4,
    OP_STOP      = 4'd5,
    OP_UP        = 4'd6,
    OP_DOWN      = 4'd7,
    OP_REVERSE   = 4'd8,
    OP_STEP      = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_CHK1,
    ST_WAIT1,
    ST_MUL2,
    ST_CHK2,
    ST_WAIT2,
    ST_DONE
  } state_e;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BACK = 2'd2;

  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd0;
  localparam logic [2:0] REG_PULSES       = 3'd1;
  localparam logic [2:0] REG_PERIOD_BIAS  = 3'd2;
  localparam logic [2:0] REG_COUNT_WRAP   = 3'd3;
  localparam logic [2:0] REG_LINK_TIMEOUT = 3'd4;

  localparam int unsigned CFG_AW = 5;

  localparam logic [13:0] SPEED_MAX_CENTI     = 14'd9999;
  localparam logic [13:0] RST_SPEED_LIMIT     = 14'd9999;
  localparam logic [15:0] RST_PULSES          = 16'd2048;
  localparam logic [15:0] RST_PERIOD_BIAS     = 16'd0;
  localparam logic [31:0] RST_COUNT_WRAP      = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_LINK_TIMEOUT    = 16'd300;
  localparam logic [1:0]  RST_BACK_PHASE      = 2'd3;

  // microseconds per minute times 100, for centi-rpm
  localparam logic [32:0] US_CENTI_PER_MIN = 33'd6000000000;
  localparam logic [5:0]  DIV_STEPS        = 6'd33;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] dir_char;
    logic [7:0] tens_char;
    logic [7:0] ones_char;
    logic [7:0] tenths_char;
    logic [7:0] hundredths_char;
    logic       limit_a;
    logic       limit_b;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  coil_drive;
    logic [1:0]  run_mode;
    logic [13:0] preset_speed_centi;
    logic [31:0] period_us;
    logic [15:0] actual_speed_centi;
    logic [31:0] step_count;
    logic        link_up;
    logic        status_request;
    logic        reverse_request;
  } res_t;

  typedef struct packed {
    logic [13:0] speed_limit_centi;
    logic [15:0] pulses_per_rev;
    logic [15:0] period_bias_us;
    logic [31:0] step_count_wrap;
    logic [15:0] link_timeout_ticks;
  } cfg_t;

  function automatic logic [3:0] digit_of(input logic [7:0] ch);
    logic [3:0] d;
    d = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch[3:0];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/scc_div.sv -----
// Restoring divider: fixed 33-bit dividend by a 48-bit divisor, one quotient bit a cycle
`default_nettype none
module scc_div import scc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] divisor_i,
  output logic             done_o,
  output logic [32:0]      quotient_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] div_q, div_d;
  logic [32:0] acc_q, acc_d;
  logic [48:0] shifted;
  logic [48:0] diff;
  logic        ge;

  assign shifted = {rem_q, acc_q[32]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      rem_d = '0;
      div_d = divisor_i;
      acc_d = US_CENTI_PER_MIN;
    end else if (cnt_q != 6'd0) begin
      rem_d  = ge ? diff[47:0] : shifted[47:0];
      acc_d  = {acc_q[31:0], ge};
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    acc_q <= acc_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule
`default_nettype wire

// ----- rtl/scc_cfg.sv -----
// APB register file holding the controller configuration
`default_nettype none
module scc_cfg import scc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_SPEED_LIMIT:  cfg_d.speed_limit_centi  = pwdata[13:0];
        REG_PULSES:       cfg_d.pulses_per_rev     = pwdata[15:0];
        REG_PERIOD_BIAS:  cfg_d.period_bias_us     = pwdata[15:0];
        REG_COUNT_WRAP:   cfg_d.step_count_wrap    = pwdata;
        REG_LINK_TIMEOUT: cfg_d.link_timeout_ticks = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_LIMIT:  prdata = {18'd0, cfg_q.speed_limit_centi};
      REG_PULSES:       prdata = {16'd0, cfg_q.pulses_per_rev};
      REG_PERIOD_BIAS:  prdata = {16'd0, cfg_q.period_bias_us};
      REG_COUNT_WRAP:   prdata = cfg_q.step_count_wrap;
      REG_LINK_TIMEOUT: prdata = {16'd0, cfg_q.link_timeout_ticks};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit_centi  <= RST_SPEED_LIMIT;
      cfg_q.pulses_per_rev     <= RST_PULSES;
      cfg_q.period_bias_us     <= RST_PERIOD_BIAS;
      cfg_q.step_count_wrap    <= RST_COUNT_WRAP;
      cfg_q.link_timeout_ticks <= RST_LINK_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/stepper_command_controller_unit.sv -----
// Top level of the stepper command controller: command decode, sequencer and output register
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | cmd_t  in_data_i
//  out     | output    | out_valid_o/out_stall_i | res_t  out_data_o
//  cfg     | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// Commands and non-running ticks pass through the done state to the output register.
// A running tick makes two passes through the shared 33-step restoring divider, each
// behind one pass through the 16x32 multiplier; a zero product skips its divider pass.
// No clearing pass after reset; items are taken from the first cycle.
// The next item is accepted once the sequencer is idle; a stalled result
// waits in the output register.
`default_nettype none
module stepper_command_controller_unit import scc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cmd_t              in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output res_t                   out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t cfg;

  state_e state_q, state_d;

  logic [1:0]  mode_q, mode_d;
  logic [13:0] preset_q, preset_d;
  logic [31:0] period_q, period_d;
  logic [15:0] actual_q, actual_d;
  logic [1:0]  fph_q, fph_d;
  logic [1:0]  bph_q, bph_d;
  logic [3:0]  coil_q, coil_d;
  logic [31:0] cnt_q, cnt_d;
  logic        link_q, link_d;
  logic [15:0] wd_q, wd_d;
  logic        stat_q, stat_d;
  logic        rev_q, rev_d;
  logic [47:0] prod_q, prod_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_data_q, out_data_d;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic [32:0] quo;
  logic [15:0] wd_dec;
  logic        tick_run;
  logic [13:0] seff;
  logic [31:0] mul_b;
  logic [3:0]  dir_d;
  logic [32:0] cnt_inc;
  logic [33:0] per_sum;

  scc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (prod_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign wd_dec   = wd_q - 16'd1;
  assign tick_run = (mode_q != MODE_STOP) && (wd_dec != 16'd0);
  assign seff     = (preset_q > cfg.speed_limit_centi) ? cfg.speed_limit_centi : preset_q;
  assign mul_b    = (state_q == ST_MUL1) ? {18'd0, seff} : period_q;
  assign dir_d    = digit_of(in_data_i.dir_char);
  assign cnt_inc  = {1'b0, cnt_q} + 33'd1;
  assign per_sum  = {1'b0, quo} + {18'd0, cfg.period_bias_us};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.opcode == OP_TICK && tick_run) ? ST_MUL1 : ST_DONE;
        end
      end
      ST_MUL1:  state_d = ST_CHK1;
      ST_CHK1:  state_d = (prod_q == 48'd0) ? ST_MUL2 : ST_WAIT1;
      ST_WAIT1: state_d = div_done ? ST_MUL2 : ST_WAIT1;
      ST_MUL2:  state_d = ST_CHK2;
      ST_CHK2:  state_d = (prod_q == 48'd0) ? ST_DONE : ST_WAIT2;
      ST_WAIT2: state_d = div_done ? ST_DONE : ST_WAIT2;
      ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = (state_q == ST_CHK1 || state_q == ST_CHK2) && (prod_q != 48'd0);
    out_load   = (state_q == ST_DONE) && out_free;
  end

  // controller state update
  always_comb begin
    mode_d   = mode_q;
    preset_d = preset_q;
    period_d = period_q;
    actual_d = actual_q;
    fph_d    = fph_q;
    bph_d    = bph_q;
    coil_d   = coil_q;
    cnt_d    = cnt_q;
    link_d   = link_q;
    wd_d     = wd_q;
    stat_d   = stat_q;
    rev_d    = rev_q;
    prod_d   = prod_q;

    if (accept) begin
      stat_d = 1'b0;
      rev_d  = 1'b0;
      case (in_data_i.opcode)
        OP_TICK: begin
          rev_d = (!in_data_i.limit_a || !in_data_i.limit_b) && (mode_q != MODE_STOP);
          if (wd_dec == 16'd0) begin
            link_d   = 1'b0;
            mode_d   = MODE_STOP;
            coil_d   = '0;
            period_d = '0;
            actual_d = '0;
            preset_d = '0;
            wd_d     = cfg.link_timeout_ticks;
          end else begin
            wd_d = wd_dec;
          end
        end
        OP_KEEPALIVE: begin
          link_d = 1'b1;
          wd_d   = cfg.link_timeout_ticks;
        end
        OP_STATUS: begin
          link_d = 1'b1;
          wd_d   = cfg.link_timeout_ticks;
          stat_d = 1'b1;
        end
        OP_SET: begin
          mode_d   = (dir_d > 4'd2) ? MODE_STOP : dir_d[1:0];
          preset_d = 14'(digit_of(in_data_i.tens_char)) * 14'd1000
                   + 14'(digit_of(in_data_i.ones_char)) * 14'd100
                   + 14'(digit_of(in_data_i.tenths_char)) * 14'd10
                   + 14'(digit_of(in_data_i.hundredths_char));
        end
        OP_CLR_COUNT: cnt_d = '0;
        OP_STOP: begin
          mode_d   = MODE_STOP;
          coil_d   = '0;
          period_d = '0;
          actual_d = '0;
          preset_d = '0;
        end
        OP_UP: begin
          if (preset_q < SPEED_MAX_CENTI) begin
            preset_d = preset_q + 14'd1;
          end
        end
        OP_DOWN: begin
          if (preset_q != 14'd0) begin
            preset_d = preset_q - 14'd1;
          end
        end
        OP_REVERSE: begin
          if (mode_q != MODE_STOP) begin
            mode_d   = (mode_q != MODE_BACK) ? MODE_BACK : MODE_FWD;
            coil_d   = '0;
            period_d = '0;
            actual_d = '0;
          end
        end
        OP_STEP: begin
          if (mode_q == MODE_FWD || mode_q == MODE_BACK) begin
            if (mode_q == MODE_FWD) begin
              coil_d = 4'd1 << fph_q;
              fph_d  = fph_q + 2'd1;
            end else begin
              coil_d = 4'd1 << bph_q;
              bph_d  = bph_q - 2'd1;
            end
            cnt_d = (cnt_inc >= {1'b0, cfg.step_count_wrap}) ? 32'd0 : cnt_inc[31:0];
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      ST_MUL1, ST_MUL2: prod_d = {32'd0, cfg.pulses_per_rev} * {16'd0, mul_b};
      ST_CHK1: begin
        if (prod_q == 48'd0) begin
          period_d = '1;
        end
      end
      ST_WAIT1: begin
        if (div_done) begin
          period_d = (per_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : per_sum[31:0];
        end
      end
      ST_CHK2: begin
        if (prod_q == 48'd0) begin
          actual_d = '1;
        end
      end
      ST_WAIT2: begin
        if (div_done) begin
          actual_d = (quo[32:16] != 17'd0) ? 16'hFFFF : quo[15:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_d.coil_drive         = coil_q;
    out_data_d.run_mode           = mode_q;
    out_data_d.preset_speed_centi = preset_q;
    out_data_d.period_us          = period_q;
    out_data_d.actual_speed_centi = actual_q;
    out_data_d.step_count         = cnt_q;
    out_data_d.link_up            = link_q;
    out_data_d.status_request     = stat_q;
    out_data_d.reverse_request    = rev_q;
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_STOP;
      preset_q    <= '0;
      period_q    <= '0;
      actual_q    <= '0;
      fph_q       <= '0;
      bph_q       <= RST_BACK_PHASE;
      coil_q      <= '0;
      cnt_q       <= '0;
      link_q      <= 1'b0;
      wd_q        <= RST_LINK_TIMEOUT;
      stat_q      <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      preset_q    <= preset_d;
      period_q    <= period_d;
      actual_q    <= actual_d;
      fph_q       <= fph_d;
      bph_q       <= bph_d;
      coil_q      <= coil_d;
      cnt_q       <= cnt_d;
      link_q      <= link_d;
      wd_q        <= wd_d;
      stat_q      <= stat_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == ST_IDLE)
    else $error("item accepted while sequencer busy");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_coil_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(coil_q))
    else $error("more than one coil driven");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT1 || state_q == ST_WAIT2))
    else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the stepper command controller: command stream, checks, register setup
module tb;
  import scc_pkg::*;

  localparam logic [3:0]       OP_NOOP_FIRST  = 4'd10;
  localparam logic [3:0]       OP_NOOP_LAST   = 4'd15;
  localparam logic [7:0]       ASCII_ZERO     = 8'h30;
  localparam longint unsigned  USEC_CENTI_MIN = 64'd6000000000;
  localparam int               SETTLE_CYCLES  = 120;
  localparam int               QUIET_LIMIT    = 3000;
  localparam int               HOLD_AFTER     = 300;
  localparam int               HOLD_CYCLES    = 400;
  localparam int               PHASE_ITEMS    = 185;
  localparam int               MAX_REPORTS    = 40;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall_o;
  cmd_t              in_data     = '0;
  logic              out_valid_o;
  logic              out_stall   = 1'b0;
  res_t              out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [CFG_AW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  stepper_command_controller_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk_i = ~clk_i;

  // controller state as predicted
  cfg_t        cfg_m;
  logic [1:0]  m_mode    = MODE_STOP;
  logic [13:0] m_preset  = '0;
  logic [31:0] m_period  = '0;
  logic [15:0] m_actual  = '0;
  logic [1:0]  m_fwd_ph  = 2'd0;
  logic [1:0]  m_back_ph = RST_BACK_PHASE;
  logic [3:0]  m_coils   = '0;
  logic [31:0] m_steps   = '0;
  logic        m_link    = 1'b0;
  logic [15:0] m_wdog    = RST_LINK_TIMEOUT;

  cmd_t cmd_backlog[$];
  res_t expected_res[$];

  int   err_count    = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  logic in_taken     = 1'b0;
  int   gap_left     = 0;
  int   burst_left   = 1;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   pattern_left = 0;
  int   stall_pct    = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    end
  endtask

  function automatic logic [3:0] ascii_val(input logic [7:0] ch);
    return (ch >= ASCII_ZERO && ch <= ASCII_ZERO + 8'd9) ? 4'(ch - ASCII_ZERO) : 4'd0;
  endfunction

  function automatic void stop_motor();
    m_mode   = MODE_STOP;
    m_coils  = '0;
    m_period = '0;
    m_actual = '0;
    m_preset = '0;
  endfunction

  function automatic res_t predict_response(input cmd_t c);
    res_t            r;
    logic            status_p;
    logic            reverse_p;
    logic            bump;
    logic [1:0]      old_mode;
    logic [13:0]     kept;
    logic [3:0]      d;
    longint unsigned s_eff, den, quo, per, nxt;
    status_p  = 1'b0;
    reverse_p = 1'b0;
    bump      = 1'b0;
    case (c.opcode)
      OP_TICK: begin
        if ((!c.limit_a || !c.limit_b) && m_mode != MODE_STOP) reverse_p = 1'b1;
        m_wdog = m_wdog - 16'd1;
        if (m_wdog == 16'd0) begin
          m_link = 1'b0;
          stop_motor();
          m_wdog = cfg_m.link_timeout_ticks;
        end
        if (m_mode != MODE_STOP) begin
          s_eff = 64'((m_preset > cfg_m.speed_limit_centi) ? cfg_m.speed_limit_centi
                                                           : m_preset);
          den = 64'(cfg_m.pulses_per_rev) * s_eff;
          if (den == 0) begin
            per = 64'hFFFF_FFFF;
          end else begin
            quo = USEC_CENTI_MIN / den + 64'(cfg_m.period_bias_us);
            per = (quo > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo;
          end
          m_period = per[31:0];
          den = 64'(cfg_m.pulses_per_rev) * per;
          if (den == 0) begin
            m_actual = 16'hFFFF;
          end else begin
            quo = USEC_CENTI_MIN / den;
            m_actual = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
          end
        end
      end
      OP_KEEPALIVE, OP_STATUS: begin
        m_link = 1'b1;
        m_wdog = cfg_m.link_timeout_ticks;
        status_p = (c.opcode == OP_STATUS);
      end
      OP_SET: begin
        d = ascii_val(c.dir_char);
        m_mode = (d > 4'd2) ? MODE_STOP : d[1:0];
        m_preset = 14'((ascii_val(c.tens_char) * 10 + ascii_val(c.ones_char)) * 100
                       + ascii_val(c.tenths_char) * 10 + ascii_val(c.hundredths_char));
      end
      OP_CLR_COUNT: m_steps = '0;
      OP_STOP: stop_motor();
      OP_UP: if (m_preset < SPEED_MAX_CENTI) m_preset = m_preset + 14'd1;
      OP_DOWN: if (m_preset > 14'd0) m_preset = m_preset - 14'd1;
      OP_REVERSE: begin
        if (m_mode != MODE_STOP) begin
          old_mode = m_mode;
          kept = m_preset;
          stop_motor();
          m_mode = (old_mode != MODE_BACK) ? MODE_BACK : MODE_FWD;
          m_preset = kept;
        end
      end
      OP_STEP: begin
        if (m_mode == MODE_FWD) begin
          m_coils = 4'b0001 << m_fwd_ph;
          m_fwd_ph = m_fwd_ph + 2'd1;
          bump = 1'b1;
        end else if (m_mode == MODE_BACK) begin
          m_coils = 4'b0001 << m_back_ph;
          m_back_ph = m_back_ph - 2'd1;
          bump = 1'b1;
        end
        if (bump) begin
          nxt = 64'(m_steps);
          nxt = nxt + 64'd1;
          m_steps = (nxt >= 64'(cfg_m.step_count_wrap)) ? 32'd0 : nxt[31:0];
        end
      end
      default: ;
    endcase
    r.coil_drive         = m_coils;
    r.run_mode           = m_mode;
    r.preset_speed_centi = m_preset;
    r.period_us          = m_period;
    r.actual_speed_centi = m_actual;
    r.step_count         = m_steps;
    r.link_up            = m_link;
    r.status_request     = status_p;
    r.reverse_request    = reverse_p;
    return r;
  endfunction

  task automatic check_result(input res_t got, input res_t want);
    if (got.coil_drive !== want.coil_drive)
      report_mismatch("coil_drive", 64'(got.coil_drive), 64'(want.coil_drive));
    if (got.run_mode !== want.run_mode)
      report_mismatch("run_mode", 64'(got.run_mode), 64'(want.run_mode));
    if (got.preset_speed_centi !== want.preset_speed_centi)
      report_mismatch("preset_speed_centi", 64'(got.preset_speed_centi),
                      64'(want.preset_speed_centi));
    if (got.period_us !== want.period_us)
      report_mismatch("period_us", 64'(got.period_us), 64'(want.period_us));
    if (got.actual_speed_centi !== want.actual_speed_centi)
      report_mismatch("actual_speed_centi", 64'(got.actual_speed_centi),
                      64'(want.actual_speed_centi));
    if (got.step_count !== want.step_count)
      report_mismatch("step_count", 64'(got.step_count), 64'(want.step_count));
    if (got.link_up !== want.link_up)
      report_mismatch("link_up", 64'(got.link_up), 64'(want.link_up));
    if (got.status_request !== want.status_request)
      report_mismatch("status_request", 64'(got.status_request), 64'(want.status_request));
    if (got.reverse_request !== want.reverse_request)
      report_mismatch("reverse_request", 64'(got.reverse_request),
                      64'(want.reverse_request));
  endtask

  // monitor, prediction and activity watchdog
  always @(posedge clk_i) begin
    in_taken <= in_valid && !in_stall_o;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        expected_res.push_back(predict_response(in_data));
      end
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          check_result(out_data_o, expected_res.pop_front());
        end
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // sender: bursts of items with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (gap_left > 0 || cmd_backlog.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= cmd_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern, plus one long hold-off so the block backs up
  always @(negedge clk_i) begin
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(10, 120);
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] val,
                           output logic [31:0] rd);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] stored;
    logic [31:0] rd;
    stored = '0;
    case (idx)
      REG_SPEED_LIMIT: begin
        cfg_m.speed_limit_centi = val[13:0];
        stored = 32'(cfg_m.speed_limit_centi);
      end
      REG_PULSES: begin
        cfg_m.pulses_per_rev = val[15:0];
        stored = 32'(cfg_m.pulses_per_rev);
      end
      REG_PERIOD_BIAS: begin
        cfg_m.period_bias_us = val[15:0];
        stored = 32'(cfg_m.period_bias_us);
      end
      REG_COUNT_WRAP: begin
        cfg_m.step_count_wrap = val;
        stored = cfg_m.step_count_wrap;
      end
      REG_LINK_TIMEOUT: begin
        cfg_m.link_timeout_ticks = val[15:0];
        stored = 32'(cfg_m.link_timeout_ticks);
      end
      default: ;
    endcase
    apb_cycle(1'b1, idx, val, rd);
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== stored) report_mismatch("register read-back", 64'(rd), 64'(stored));
  endtask

  task automatic apply_settings(input logic [31:0] lim, input logic [31:0] ppr,
                                input logic [31:0] bias, input logic [31:0] wrap,
                                input logic [31:0] tmo);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_PULSES, ppr);
    write_reg(REG_PERIOD_BIAS, bias);
    write_reg(REG_COUNT_WRAP, wrap);
    write_reg(REG_LINK_TIMEOUT, tmo);
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || expected_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(input logic [3:0] op, input logic [7:0] dir, input logic [7:0] tens,
                              input logic [7:0] ones, input logic [7:0] tenths,
                              input logic [7:0] hund, input logic la, input logic lb);
    cmd_t c;
    c.opcode          = op;
    c.dir_char        = dir;
    c.tens_char       = tens;
    c.ones_char       = ones;
    c.tenths_char     = tenths;
    c.hundredths_char = hund;
    c.limit_a         = la;
    c.limit_b         = lb;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c.dir_char        = 8'($urandom_range(0, 255));
    c.tens_char       = 8'($urandom_range(0, 255));
    c.ones_char       = 8'($urandom_range(0, 255));
    c.tenths_char     = 8'($urandom_range(0, 255));
    c.hundredths_char = 8'($urandom_range(0, 255));
    c.limit_a         = ($urandom_range(0, 7) != 0);
    c.limit_b         = ($urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      c.opcode = OP_TICK;
    end else if (pick < 50) begin
      c.opcode = OP_STEP;
    end else if (pick < 60) begin
      c.opcode = OP_SET;
      if ($urandom_range(0, 6) != 0) begin
        c.dir_char = ($urandom_range(0, 5) == 0) ? 8'(ASCII_ZERO + $urandom_range(0, 9))
                                                 : 8'(ASCII_ZERO + $urandom_range(1, 2));
        if ($urandom_range(0, 9) == 0) begin
          c.tens_char       = ASCII_ZERO + 8'd9;
          c.ones_char       = ASCII_ZERO + 8'd9;
          c.tenths_char     = ASCII_ZERO + 8'd9;
          c.hundredths_char = ASCII_ZERO + 8'd9;
        end else begin
          c.tens_char       = 8'(ASCII_ZERO + $urandom_range(0, 9));
          c.ones_char       = 8'(ASCII_ZERO + $urandom_range(0, 9));
          c.tenths_char     = 8'(ASCII_ZERO + $urandom_range(0, 9));
          c.hundredths_char = 8'(ASCII_ZERO + $urandom_range(0, 9));
        end
      end
    end else if (pick < 68) begin
      c.opcode = OP_KEEPALIVE;
    end else if (pick < 72) begin
      c.opcode = OP_STATUS;
    end else if (pick < 78) begin
      c.opcode = OP_UP;
    end else if (pick < 84) begin
      c.opcode = OP_DOWN;
    end else if (pick < 88) begin
      c.opcode = OP_REVERSE;
    end else if (pick < 91) begin
      c.opcode = OP_STOP;
    end else if (pick < 94) begin
      c.opcode = OP_CLR_COUNT;
    end else begin
      c.opcode = 4'($urandom_range(OP_NOOP_FIRST, OP_NOOP_LAST));
    end
    return c;
  endfunction

  initial begin
    int phase;
    int i;
    cfg_m.speed_limit_centi  = RST_SPEED_LIMIT;
    cfg_m.pulses_per_rev     = RST_PULSES;
    cfg_m.period_bias_us     = RST_PERIOD_BIAS;
    cfg_m.step_count_wrap    = RST_COUNT_WRAP;
    cfg_m.link_timeout_ticks = RST_LINK_TIMEOUT;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pass on reset settings
    cmd_backlog.push_back(mk(OP_TICK, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STATUS, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_KEEPALIVE, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_SET, "1", "1", "2", "3", "4", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_TICK, "0", "0", "0", "0", "0", 1'b0, 1'b1));
    cmd_backlog.push_back(mk(OP_STEP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STEP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_TICK, "0", "0", "0", "0", "0", 1'b1, 1'b0));
    cmd_backlog.push_back(mk(OP_UP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_DOWN, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_REVERSE, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STEP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STEP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_TICK, "0", "0", "0", "0", "0", 1'b0, 1'b0));
    // direction digit above 2 stops, full-scale speed
    cmd_backlog.push_back(mk(OP_SET, "9", "9", "9", "9", "9", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_UP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    // non-digit characters read as zero
    cmd_backlog.push_back(mk(OP_SET, 8'hFF, 8'hFF, 8'h2F, 8'h3A, 8'h00, 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_DOWN, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_REVERSE, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STEP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    // running backwards at zero speed: period saturates
    cmd_backlog.push_back(mk(OP_SET, "2", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_TICK, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_CLR_COUNT, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_STOP, "0", "0", "0", "0", "0", 1'b1, 1'b1));
    cmd_backlog.push_back(mk(OP_NOOP_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_settings(32'd9999, 32'd65535, 32'd65535, 32'hFFFF_FFFF, 32'd65535);
        1: apply_settings(32'd1, 32'd1, 32'd0, 32'd1, 32'd1);
        2: apply_settings(32'd500, 32'd0, 32'd100, 32'd0, 32'd0);
        3: apply_settings($urandom_range(1, 9999), $urandom_range(1, 65535),
                          $urandom_range(0, 65535), $urandom_range(2, 40),
                          $urandom_range(3, 60));
        default: apply_settings(32'd16383, $urandom_range(1, 400), $urandom_range(0, 50),
                                $urandom_range(5, 12), 32'd300);
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) cmd_backlog.push_back(random_cmd());
      wait_drained();
    end

    if (expected_res.size() != 0)
      report_mismatch("missing results", 64'(expected_res.size()), 64'd0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/scc_pkg.sv
rtl/scc_div.sv
rtl/scc_cfg.sv
rtl/stepper_command_controller_unit.sv
tb/tb.sv
